// ===== rtl/pfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame stack allocator package
// Shared types, codes and widths of the allocator's controller and datapath.
// ----------------------------------------------------------------------------
package pfsa_pkg;

    localparam int PAGE_TOTAL_DEF = 1024;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int OP_W        = 2;
    localparam int CNT_W       = 11;
    localparam int ADDR_W      = 32;
    localparam int ST_W        = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - ST_W;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_ZERO  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CLEAR,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    idx_clr;
        logic    idx_inc;
        logic    fill_init;
        logic    fill_step;
        logic    rd_issue;
        logic    capture;
        logic    clear_step;
        logic    top_zero;
        logic    top_add;
        logic    free_do;
        logic    st_set;
        status_t st_code;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic oom;
        logic top_empty;
        logic fill_last;
        logic rd_zero;
        logic scan_last;
        logic clear_last;
        logic n_zero;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/pfsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences init fill, alloc scan and clear, free, and result hand-off.
// ----------------------------------------------------------------------------
module pfsa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pfsa_pkg::sts_t sts,
    output pfsa_pkg::cmd_t cmd
);
    import pfsa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_INIT:  state_next = S_FILL;
                    OP_ALLOC: state_next = sts.oom ? S_FINISH : S_SCAN_RD;
                    default:  state_next = S_FINISH;
                endcase
            end
            S_FILL:
            begin
                if (sts.fill_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (sts.rd_zero || (sts.scan_last && sts.n_zero))
                begin
                    state_next = S_FINISH;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_INIT:
                    begin
                        cmd.idx_clr   = 1'b1;
                        cmd.fill_init = 1'b1;
                    end
                    OP_ALLOC:
                    begin
                        cmd.idx_clr = 1'b1;
                        if (sts.oom)
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_OOM;
                        end
                    end
                    OP_FREE:
                    begin
                        if (sts.top_empty)
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.free_do = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                cmd.idx_inc   = 1'b1;
                cmd.top_zero  = sts.fill_last;
            end
            S_SCAN_RD:
            begin
                cmd.rd_issue = 1'b1;
            end
            S_SCAN_CHK:
            begin
                cmd.capture = 1'b1;
                if (sts.rd_zero)
                begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = ST_ZERO;
                end
                else if (sts.scan_last)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                cmd.idx_inc    = 1'b1;
                cmd.top_add    = sts.clear_last;
            end
            S_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/pfsa_datapath.sv =====
// ----------------------------------------------------------------------------
// Allocator datapath
// Stack memory, top index, walk counter, fill address and result register.
// ----------------------------------------------------------------------------
module pfsa_datapath #(
    parameter int PAGE_TOTAL = pfsa_pkg::PAGE_TOTAL_DEF,
    parameter int PAGE_BYTES = pfsa_pkg::PAGE_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pfsa_pkg::ADDR_W-1:0]        cfg_wdata,
    input  logic [pfsa_pkg::OP_W-1:0]          in_op,
    input  logic [pfsa_pkg::CNT_W-1:0]         in_count,
    input  logic [pfsa_pkg::ADDR_W-1:0]        in_addr,
    input  pfsa_pkg::cmd_t                     cmd,
    output pfsa_pkg::sts_t                     sts,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [pfsa_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import pfsa_pkg::*;

    localparam int TW = $clog2(PAGE_TOTAL + 1);
    localparam int AW = (PAGE_TOTAL > 1) ? $clog2(PAGE_TOTAL) : 1;
    localparam int SW = ((TW > CNT_W) ? TW : CNT_W) + 1;

    logic [ADDR_W-1:0]      base_reg,     base_next;
    op_t                    op_reg,       op_next;
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;
    logic [ADDR_W-1:0]      paddr_reg,    paddr_next;
    logic [TW-1:0]          top_reg,      top_next;
    logic [TW-1:0]          idx_reg,      idx_next;
    logic [ADDR_W-1:0]      fill_reg,     fill_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    status_t                st_reg,       st_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [SW-1:0]     top_ext, n_ext, idx_ext;
    logic [TW-1:0]     slot, top_m1;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ADDR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_rdata;

    assign top_ext = SW'(top_reg);
    assign n_ext   = SW'(cnt_reg);
    assign idx_ext = SW'(idx_reg);
    assign slot    = top_reg + idx_reg;
    assign top_m1  = top_reg - TW'(1);

    assign ram_we    = cmd.fill_step | cmd.clear_step | cmd.free_do;
    assign ram_waddr = cmd.fill_step ? idx_reg[AW-1:0] :
                       cmd.free_do   ? top_m1[AW-1:0]  : slot[AW-1:0];
    assign ram_wdata = cmd.fill_step ? fill_reg :
                       cmd.free_do   ? paddr_reg : '0;

    pfsa_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (PAGE_TOTAL),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (slot[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.op         = op_reg;
        sts.oom        = (top_ext + n_ext > SW'(PAGE_TOTAL)) || (top_reg == TW'(PAGE_TOTAL));
        sts.top_empty  = (top_reg == '0);
        sts.fill_last  = (idx_reg == TW'(PAGE_TOTAL - 1));
        sts.rd_zero    = (ram_rdata == '0);
        sts.scan_last  = (idx_ext + SW'(1) >= n_ext);
        sts.clear_last = (idx_ext + SW'(1) == n_ext);
        sts.n_zero     = (cnt_reg == '0);
        sts.out_free   = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        base_next      = cfg_we ? cfg_wdata : base_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        paddr_next     = paddr_reg;
        top_next       = top_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        res_addr_next  = res_addr_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.load)
        begin
            op_next       = op_t'(in_op);
            cnt_next      = in_count;
            paddr_next    = in_addr;
            res_addr_next = '0;
            st_next       = ST_OK;
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + TW'(1);
        end
        if (cmd.fill_init)
        begin
            fill_next = base_reg;
        end
        else if (cmd.fill_step)
        begin
            fill_next = fill_reg + ADDR_W'(PAGE_BYTES);
        end
        // The first entry read in a scan is the address handed out.
        if (cmd.capture && (idx_reg == '0))
        begin
            res_addr_next = ram_rdata;
        end
        if (cmd.top_zero)
        begin
            top_next = '0;
        end
        else if (cmd.top_add)
        begin
            top_next = TW'(top_ext + n_ext);
        end
        else if (cmd.free_do)
        begin
            top_next = top_m1;
        end
        if (cmd.st_set)
        begin
            st_next = cmd.st_code;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{OUT_PAD_W{1'b0}}, st_reg,
                              (st_reg == ST_OK) ? res_addr_reg : {ADDR_W{1'b0}}};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            top_reg       <= TW'(PAGE_TOTAL);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cnt_reg      <= cnt_next;
        paddr_reg    <= paddr_next;
        idx_reg      <= idx_next;
        fill_reg     <= fill_next;
        res_addr_reg <= res_addr_next;
        st_reg       <= st_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/page_frame_stack_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Page frame stack allocator
// Free-list stack of page frame addresses with init, alloc and free commands.
// ----------------------------------------------------------------------------
// Usage: one command enters per transfer on the s_t* channel and yields
// exactly one result transfer on the m_t* channel. cfg_we/cfg_wdata set the
// base address used by init; write it only while the block is idle.
// The block works on one command at a time. From input transfer to result
// valid, the controller walks through the stack memory one entry at a time:
//   free, nop, or an alloc that is out of memory: decode, then result
//   init: a write to every entry (one memory write per cycle), then result
//   alloc of n pages: read and check each of max(n,1) entries, then clear each of n;
//   a zero entry ends the scan right after the read that finds it.
// s_tready rises again at the same edge at which the result becomes valid,
// so a new command is taken while the previous result still waits. If the
// receiver stalls, the result holds in the output register and the next
// result waits in its final state until the register frees up.
// Reset empties the free list (top at PAGE_TOTAL, all pages given out) and
// clears the base register; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_unit #(
    parameter int PAGE_TOTAL = pfsa_pkg::PAGE_TOTAL_DEF,
    parameter int PAGE_BYTES = pfsa_pkg::PAGE_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pfsa_pkg::ADDR_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op [1:0], page_count [12:2], page_addr [44:13], zeros above
    input  logic [pfsa_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_addr [31:0], status [33:32], zeros above
    output logic [pfsa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import pfsa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfsa_datapath #(
        .PAGE_TOTAL (PAGE_TOTAL),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_tdata[OP_W-1:0]),
        .in_count  (s_tdata[OP_W+CNT_W-1:OP_W]),
        .in_addr   (s_tdata[OP_W+CNT_W+ADDR_W-1:OP_W+CNT_W]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTH
    // A failed command never hands out an address.
    a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[ADDR_W+ST_W-1:ADDR_W] != ST_OK) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("error result carries a nonzero address");

    // Only one command is in flight: input is closed right after a transfer.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in progress");

    // A new result appears only after a command has been worked on.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced without a command in progress");
`endif

endmodule
